/* rtl/hsi_pkg.sv */
// Shared types and constants for the hash set intersection core.
// Has no dependencies; the core module refers to it by scoped names.
`timescale 1ns / 1ps

package hsi_pkg;

	localparam int KEY_W  = 31;
	localparam int FUNC_W = 2;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [FUNC_W-1:0] func_t;

	// Operation codes carried by the func field.
	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_PROBE  = 2'd1;
	localparam func_t FUNC_CLEAR  = 2'd2;

endpackage

/* rtl/hash_set_intersection_core.sv */
// Hash set intersection core: bucket index pipeline, bucket row memories, way compare.
// Depends on hsi_pkg for the key type and the operation codes.
// Pipeline: input register, quotient estimate, back-multiply, row read and compare, result register.
// Throughput: one transaction per cycle unless out_stall holds the result; a clear stalls the input
// while the valid memory is swept one row per cycle.
// Reset: the same sweep of all BUCKETS rows runs with input stalled; keys are not reset.
`timescale 1ns / 1ps

module hash_set_intersection_core #(
	parameter int BUCKETS = 64,
	parameter int WAYS    = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [hsi_pkg::FUNC_W-1:0] func,
	input  logic [hsi_pkg::KEY_W-1:0]  key,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      emit,
	output logic [hsi_pkg::KEY_W-1:0]  value,
	output logic                      full_res
);

	// The bucket index is key modulo BUCKETS. It is computed with a reciprocal:
	// quotient estimate q = (key * RECIP) >> SHIFT is the true quotient or one less,
	// so the remainder key - q * BUCKETS lies below twice BUCKETS and one
	// compare-and-subtract finishes it. RECIP always fits in 32 bits.
	localparam int KW       = hsi_pkg::KEY_W;
	localparam int LOG_B    = $clog2(BUCKETS);
	localparam int BW       = (BUCKETS > 1) ? LOG_B : 1;
	localparam int BCW      = $clog2(BUCKETS + 1);
	localparam int SHIFT    = KW + LOG_B;
	localparam logic [63:0] RECIP_W = (64'd1 << SHIFT) / 64'(BUCKETS);
	localparam logic [31:0] RECIP   = RECIP_W[31:0];
	localparam logic [KW:0]  BUCKETS_V = (KW + 1)'(BUCKETS);
	localparam logic [BCW-1:0] BUCKETS_C = BCW'(BUCKETS);

	typedef logic [WAYS-1:0][KW-1:0] row_t;
	typedef logic [WAYS-1:0]         vrow_t;

	// Stage 1: input register.
	logic                   v_s1;
	hsi_pkg::func_t         func_s1;
	hsi_pkg::key_t          key_s1;

	// Stage 2: quotient estimate.
	logic                   v_s2;
	hsi_pkg::func_t         func_s2;
	hsi_pkg::key_t          key_s2;
	hsi_pkg::key_t          quo_s2;

	// Stage 3: quotient times bucket count.
	logic                   v_s3;
	hsi_pkg::func_t         func_s3;
	hsi_pkg::key_t          key_s3;
	hsi_pkg::key_t          qb_s3;

	// Stage 4: bucket row read back, compare and update.
	logic                   v_s4;
	hsi_pkg::func_t         func_s4;
	hsi_pkg::key_t          key_s4;
	logic [BW-1:0]          bkt_s4;
	row_t                   rdata_s4;
	vrow_t                  rvalid_s4;

	// Stage 5: result register.
	logic                   out_valid_s5;
	logic                   emit_s5;
	hsi_pkg::key_t          value_s5;
	logic                   full_s5;

	// Store: key rows and valid rows in two memories that share one read address; a sweep writes the valid memory alone.
	row_t                   mem [BUCKETS];
	vrow_t                  vmem [BUCKETS];

	// The row written at the last pipeline step; the row read at that same step
	// returned the old contents, so it is forwarded to the next compare.
	logic                   fwd_v_q;
	logic [BW-1:0]          fwd_bkt_q;
	row_t                   fwd_row_q;
	vrow_t                  fwd_vrow_q;

	// Sweep of the valid memory after reset and after every clear. While it runs
	// the pipeline holds. The row that stage 4 read before the sweep is stale, so
	// kill_q makes that compare see an empty bucket.
	logic                   clr_busy_q;
	logic [BW-1:0]          clr_idx_q;
	logic                   kill_q;

	// The whole pipeline moves together whenever the result register can take a
	// new value and no sweep runs; otherwise input transactions are refused.
	logic                   pipe_free;
	logic                   advance;
	assign pipe_free = !out_valid_s5 || !out_stall;
	assign advance   = pipe_free && !clr_busy_q;
	assign in_stall  = !advance;

	// Stage 1 to 2: reciprocal multiply.
	logic [KW+31:0]         prod1;
	logic [KW+31:0]         quo_full;
	assign prod1    = {32'd0, key_s1} * {{KW{1'b0}}, RECIP};
	assign quo_full = prod1 >> SHIFT;

	// Stage 2 to 3: back-multiply by the bucket count. The product never exceeds
	// the key, so the low key-width bits hold it.
	logic [KW+BCW-1:0]      prod2;
	assign prod2 = {{BCW{1'b0}}, quo_s2} * {{KW{1'b0}}, BUCKETS_C};

	// Stage 3: remainder and its single correction.
	logic [KW:0]            rem_raw;
	logic [KW:0]            rem_fix;
	logic [BW-1:0]          bkt_s3;
	always_comb begin
		rem_raw = {1'b0, key_s3} - {1'b0, qb_s3};
		rem_fix = (rem_raw >= BUCKETS_V) ? (rem_raw - BUCKETS_V) : rem_raw;
		bkt_s3  = rem_fix[BW-1:0];
	end

	// Stage 4: compare every way of the bucket at once and work out the update.
	logic                   fwd_hit;
	row_t                   row_use;
	vrow_t                  vrow;
	vrow_t                  match;
	logic                   hit;
	logic                   free_found;
	logic [WAYS-1:0]        free_sel;
	logic                   wr_en;
	row_t                   wr_row;
	vrow_t                  new_vrow;
	logic                   clr_all;
	logic                   emit_d;
	logic                   full_d;

	always_comb begin
		fwd_hit = fwd_v_q && (fwd_bkt_q == bkt_s4);
		row_use = fwd_hit ? fwd_row_q : rdata_s4;
		if (kill_q) begin
			vrow = '0;
		end else if (fwd_hit) begin
			vrow = fwd_vrow_q;
		end else begin
			vrow = rvalid_s4;
		end
		for (int w = 0; w < WAYS; w++) begin
			match[w] = vrow[w] && (row_use[w] == key_s4);
		end
		hit = |match;

		// Lowest-numbered free way takes a new key.
		free_found = 1'b0;
		free_sel   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!vrow[w] && !free_found) begin
				free_sel[w] = 1'b1;
				free_found  = 1'b1;
			end
		end

		wr_en    = 1'b0;
		wr_row   = row_use;
		new_vrow = vrow;
		clr_all  = 1'b0;
		emit_d   = 1'b0;
		full_d   = 1'b0;

		case (func_s4)
			hsi_pkg::FUNC_INSERT: begin
				// A key that is already present leaves the store as it is.
				if (!hit) begin
					if (free_found) begin
						wr_en = v_s4;
						for (int w = 0; w < WAYS; w++) begin
							if (free_sel[w]) begin
								wr_row[w] = key_s4;
							end
						end
						new_vrow = vrow | free_sel;
					end else begin
						full_d = 1'b1;
					end
				end
			end
			hsi_pkg::FUNC_PROBE: begin
				// A hit removes the key, so a common key is emitted only once.
				if (hit) begin
					wr_en    = v_s4;
					new_vrow = vrow & ~match;
					emit_d   = 1'b1;
				end
			end
			hsi_pkg::FUNC_CLEAR: begin
				clr_all = 1'b1;
			end
			default: begin
				// The unused code leaves the store untouched.
			end
		endcase
	end

	// Pipeline control registers. The result register also empties when its
	// transaction is taken while the sweep holds the rest of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			out_valid_s5 <= 1'b0;
			fwd_v_q      <= 1'b0;
			kill_q       <= 1'b0;
		end else if (advance) begin
			v_s1         <= in_valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			out_valid_s5 <= v_s4;
			fwd_v_q      <= wr_en;
			kill_q       <= v_s4 && clr_all;
		end else if (!out_stall) begin
			out_valid_s5 <= 1'b0;
		end
	end

	// Sweep control: starts at reset and whenever a clear leaves stage 4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == BW'(BUCKETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end else if (advance && v_s4 && clr_all) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1    <= func;
			key_s1     <= key;
			func_s2    <= func_s1;
			key_s2     <= key_s1;
			quo_s2     <= quo_full[KW-1:0];
			func_s3    <= func_s2;
			key_s3     <= key_s2;
			qb_s3      <= prod2[KW-1:0];
			func_s4    <= func_s3;
			key_s4     <= key_s3;
			bkt_s4     <= bkt_s3;
			emit_s5    <= emit_d;
			value_s5   <= emit_d ? key_s4 : '0;
			full_s5    <= full_d;
			fwd_bkt_q  <= bkt_s4;
			fwd_row_q  <= wr_row;
			fwd_vrow_q <= new_vrow;
		end
	end

	// Bucket row memories: one row write and one registered row read per step.
	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			mem[bkt_s4] <= wr_row;
		end
		if (clr_busy_q) begin
			vmem[clr_idx_q] <= '0;
		end else if (advance && wr_en) begin
			vmem[bkt_s4] <= new_vrow;
		end
		if (advance) begin
			rdata_s4  <= mem[bkt_s3];
			rvalid_s4 <= vmem[bkt_s3];
		end
	end

	assign out_valid = out_valid_s5;
	assign emit      = emit_s5;
	assign value     = value_s5;
	assign full_res  = full_s5;

endmodule
